// ===== hdl/lsvr_pkg.sv =====
// shared constants, codes and controller/datapath types of the sample voice resampler
package lsvr_pkg;

    localparam int MAX_FRAMES  = 4096;
    localparam int FRAC_BITS   = 16;
    localparam int CUR_W       = 32;
    localparam int STORE_DEPTH = 2 * MAX_FRAMES;
    localparam int FI_W        = $clog2(MAX_FRAMES);
    localparam int FR_W        = $clog2(MAX_FRAMES + 1);
    localparam int STORE_AW    = FI_W + 1;
    localparam int QI_W        = CUR_W - FRAC_BITS;
    localparam int DIV_CW      = $clog2(QI_W);
    localparam int LIM_W       = FR_W + FRAC_BITS;
    localparam int CMP_W       = (CUR_W > LIM_W) ? CUR_W : LIM_W;

    localparam int FUNC_W      = 3;
    localparam int ADDR_W      = 13;
    localparam int S_W         = 16;
    localparam int VS_W        = 2;

    localparam int FC_W        = 13;
    localparam int LB_W        = 13;
    localparam int LF_W        = 14;
    localparam int STEP_W      = 24;
    localparam int STEP_FRAC   = 16;
    localparam int GN_W        = 16;
    localparam int GAIN_SH     = 12;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 3;

    localparam int D_W         = S_W + 1;
    localparam int V_W         = S_W + 1;
    localparam int P_W         = D_W + FRAC_BITS + 1;
    localparam int G_W         = V_W + GN_W + 1;

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE = 3'd0,
        FN_PLAY  = 3'd1,
        FN_PAUSE = 3'd2,
        FN_STOP  = 3'd3,
        FN_TICK  = 3'd4
    } t_func;

    typedef enum logic [VS_W-1:0] {
        VS_INITIAL = 2'd0,
        VS_PLAYING = 2'd1,
        VS_PAUSED  = 2'd2,
        VS_STOPPED = 2'd3
    } t_vstate;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COUNT = 3'd0,
        CFG_LOOP_BEGIN  = 3'd1,
        CFG_LOOP_FINISH = 3'd2,
        CFG_LOOP_ENABLE = 3'd3,
        CFG_STEREO_MODE = 3'd4,
        CFG_PHASE_STEP  = 3'd5,
        CFG_GAIN_LEFT   = 3'd6,
        CFG_GAIN_RIGHT  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic    mem_we;
        logic    prep;
        logic    check;
        logic    div_step;
        logic    wrap_apply;
        logic    addr;
        logic    rd1;
        logic    rd2;
        logic    lerp;
        logic    sum;
        logic    gain;
        logic    out_load;
        logic    zero_out;
        logic    cur_clear;
        logic    advance;
        t_vstate vstate;
    } t_dp_cmd;

    typedef struct packed {
        logic frames_zero;
        logic at_end;
        logic can_wrap;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hdl/lsvr_in_if.sv =====
// input channel: command transactions with sample payload
interface lsvr_in_if;
    logic                             valid;
    logic                             ready;
    logic [lsvr_pkg::FUNC_W-1:0]      func;
    logic [lsvr_pkg::ADDR_W-1:0]      sample_address;
    logic signed [lsvr_pkg::S_W-1:0]  sample_value;

    modport source (output valid, output func, output sample_address, output sample_value,
                    input ready);
    modport sink   (input valid, input func, input sample_address, input sample_value,
                    output ready);
endinterface

// ===== hdl/lsvr_out_if.sv =====
// output channel: one result transaction per command
interface lsvr_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [lsvr_pkg::S_W-1:0]  left_out;
    logic signed [lsvr_pkg::S_W-1:0]  right_out;
    logic [lsvr_pkg::VS_W-1:0]        voice_state;

    modport source (output valid, output left_out, output right_out, output voice_state,
                    input ready);
    modport sink   (input valid, input left_out, input right_out, input voice_state,
                    output ready);
endinterface

// ===== hdl/looping_sample_voice_resampler_core.sv =====
// top level of the looping sample voice resampler
//
// channel   direction  handshake     payload
// i_in      in         valid/ready   func, sample_address, sample_value
// o_out     out        valid/ready   left_out, right_out, voice_state
// cfg       in         i_cfg_we      i_cfg_idx, i_cfg_data
//
// write, play, pause, stop and idle ticks go straight from idle to the result state
// a playing tick runs the controller's read, interpolate and gain sequence over the
// sample store's two read ports; a wrapping tick first adds the bit-serial loop remainder
// (one quotient bit per cycle) and the wrap of the cursor
// synchronous reset clears control, cursor and config; the sample store is not cleared
// input ready is high only while idle; a held result stalls the controller before idle
module looping_sample_voice_resampler_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    lsvr_in_if.sink                             i_in,
    lsvr_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [lsvr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lsvr_pkg::CFG_W-1:0]          i_cfg_data
);

    lsvr_pkg::t_dp_cmd   cmd;
    lsvr_pkg::t_dp_stat  stat;
    logic                in_ready;
    logic                out_valid;
    logic                in_accept;

    lsvr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_func     (i_in.func),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    lsvr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_sample_address (i_in.sample_address),
        .i_sample_value   (i_in.sample_value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (out_valid),
        .i_out_ready      (o_out.ready),
        .o_left_out       (o_out.left_out),
        .o_right_out      (o_out.right_out),
        .o_voice_state    (o_out.voice_state)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign in_accept   = i_in.valid && in_ready;

    a_no_accept_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_accept && cmd.out_load))
        else $error("input accepted while a result is loaded");

    a_load_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out.valid)
        else $error("loaded result not presented");

    a_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mem_we |-> in_accept)
        else $error("sample write without input transaction");

    a_advance_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.advance |-> (cmd.out_load && !cmd.zero_out && !cmd.cur_clear))
        else $error("cursor advance on a non-tick result");

endmodule

// ===== hdl/lsvr_store.sv =====
// sample store: one write port, two registered read ports
module lsvr_store (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [lsvr_pkg::STORE_AW-1:0]       i_waddr,
    input  logic signed [lsvr_pkg::S_W-1:0]     i_wdata,
    input  logic [lsvr_pkg::STORE_AW-1:0]       i_raddr_a,
    input  logic [lsvr_pkg::STORE_AW-1:0]       i_raddr_b,
    output logic signed [lsvr_pkg::S_W-1:0]     o_rdata_a,
    output logic signed [lsvr_pkg::S_W-1:0]     o_rdata_b
);

    logic signed [lsvr_pkg::S_W-1:0] r_mem [lsvr_pkg::STORE_DEPTH];
    logic signed [lsvr_pkg::S_W-1:0] r_rdata_a;
    logic signed [lsvr_pkg::S_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hdl/lsvr_dp.sv =====
// datapath: config registers, cursor, loop remainder, interpolation, gain and result register
module lsvr_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lsvr_pkg::t_dp_cmd                   i_cmd,
    output lsvr_pkg::t_dp_stat                  o_stat,
    input  logic [lsvr_pkg::ADDR_W-1:0]         i_sample_address,
    input  logic signed [lsvr_pkg::S_W-1:0]     i_sample_value,
    input  logic                                i_cfg_we,
    input  logic [lsvr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lsvr_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [lsvr_pkg::S_W-1:0]     o_left_out,
    output logic signed [lsvr_pkg::S_W-1:0]     o_right_out,
    output logic [lsvr_pkg::VS_W-1:0]           o_voice_state
);

    localparam int CUR_W    = lsvr_pkg::CUR_W;
    localparam int FR_W     = lsvr_pkg::FR_W;
    localparam int FI_W     = lsvr_pkg::FI_W;
    localparam int FRAC     = lsvr_pkg::FRAC_BITS;
    localparam int CMP_W    = lsvr_pkg::CMP_W;
    localparam int QI_W     = lsvr_pkg::QI_W;
    localparam int S_W      = lsvr_pkg::S_W;
    localparam int D_W      = lsvr_pkg::D_W;
    localparam int V_W      = lsvr_pkg::V_W;
    localparam int P_W      = lsvr_pkg::P_W;
    localparam int G_W      = lsvr_pkg::G_W;
    localparam int GN_W     = lsvr_pkg::GN_W;
    localparam int AW       = lsvr_pkg::STORE_AW;
    localparam int STEP_W   = lsvr_pkg::STEP_W;
    localparam int SH_L     = (FRAC >= lsvr_pkg::STEP_FRAC) ? FRAC - lsvr_pkg::STEP_FRAC : 0;
    localparam int SH_R     = (FRAC >= lsvr_pkg::STEP_FRAC) ? 0 : lsvr_pkg::STEP_FRAC - FRAC;
    localparam int STEPX_W  = STEP_W + SH_L;

    localparam logic signed [P_W-1:0] P_HALF = P_W'(1) << (FRAC - 1);
    localparam logic signed [G_W-1:0] G_HALF = G_W'(1) << (lsvr_pkg::GAIN_SH - 1);
    localparam logic signed [G_W-1:0] SAT_HI = G_W'((2 ** (S_W - 1)) - 1);
    localparam logic signed [G_W-1:0] SAT_LO = -SAT_HI - G_W'(1);

    logic [lsvr_pkg::FC_W-1:0]          r_frame_count;
    logic signed [lsvr_pkg::LB_W-1:0]   r_loop_begin;
    logic signed [lsvr_pkg::LF_W-1:0]   r_loop_finish;
    logic                               r_loop_enable;
    logic                               r_stereo;
    logic [STEP_W-1:0]                  r_phase_step;
    logic [GN_W-1:0]                    r_gain_l;
    logic [GN_W-1:0]                    r_gain_r;

    logic [CUR_W-1:0]                   r_cursor;
    logic [FR_W-1:0]                    r_frames;
    logic [FI_W-1:0]                    r_ls;
    logic [FR_W-1:0]                    r_le;
    logic [FR_W-1:0]                    r_limit;
    logic [FR_W-1:0]                    r_n;
    logic [QI_W-1:0]                    r_q;
    logic [FR_W-1:0]                    r_rem;
    logic [FRAC-1:0]                    r_dfrac;
    logic [FI_W-1:0]                    r_f0;
    logic [FI_W-1:0]                    r_f1;
    logic [FRAC-1:0]                    r_frac;
    logic signed [S_W-1:0]              r_a_l;
    logic signed [S_W-1:0]              r_a_r;
    logic signed [D_W-1:0]              r_d_l;
    logic signed [D_W-1:0]              r_d_r;
    logic signed [P_W-1:0]              r_p_l;
    logic signed [P_W-1:0]              r_p_r;
    logic signed [V_W-1:0]              r_v_l;
    logic signed [V_W-1:0]              r_v_r;
    logic signed [G_W-1:0]              r_g_l;
    logic signed [G_W-1:0]              r_g_r;
    logic                               r_out_valid;
    logic signed [S_W-1:0]              r_left;
    logic signed [S_W-1:0]              r_right;
    logic [lsvr_pkg::VS_W-1:0]          r_vstate;

    logic [FR_W-1:0]                    n_frames;
    logic [FI_W-1:0]                    n_ls;
    logic [FR_W-1:0]                    n_le;
    logic [FR_W-1:0]                    n_limit;
    logic                               loop_ok;
    logic [31:0]                        lb32;
    logic [31:0]                        lf32;
    logic [31:0]                        fr32;
    logic [CUR_W-1:0]                   d_full;
    logic [FR_W:0]                      trial;
    logic [FR_W:0]                      trial_sub;
    logic [FR_W-1:0]                    n_rem;
    logic [FR_W-1:0]                    wrap_int;
    logic [FI_W-1:0]                    f0;
    logic [FR_W-1:0]                    f0p1;
    logic [FR_W-1:0]                    last;
    logic [FI_W-1:0]                    n_f1;
    logic                               rd_ch;
    logic [AW-1:0]                      raddr_a;
    logic [AW-1:0]                      raddr_b;
    logic signed [S_W-1:0]              rd_a;
    logic signed [S_W-1:0]              rd_b;
    logic signed [D_W-1:0]              rd_diff;
    logic signed [P_W-1:0]              p_rnd_l;
    logic signed [P_W-1:0]              p_rnd_r;
    logic signed [P_W-1:0]              sh_l;
    logic signed [P_W-1:0]              sh_r;
    logic signed [FRAC:0]               frac_s;
    logic signed [GN_W:0]               gain_l_s;
    logic signed [GN_W:0]               gain_r_s;
    logic [STEPX_W-1:0]                 step_x;
    logic                               mem_we;
    logic [AW-1:0]                      waddr;

    function automatic logic signed [S_W-1:0] f_round_sat(input logic signed [G_W-1:0] g);
        logic signed [G_W-1:0] t;
        t = (g + G_HALF) >>> lsvr_pkg::GAIN_SH;
        if (t > SAT_HI) begin
            return S_W'(SAT_HI);
        end else if (t < SAT_LO) begin
            return S_W'(SAT_LO);
        end
        return S_W'(t);
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_loop_begin  <= '1;
            r_loop_finish <= '1;
            r_loop_enable <= 1'b0;
            r_stereo      <= 1'b0;
            r_phase_step  <= STEP_W'(65536);
            r_gain_l      <= GN_W'(4096);
            r_gain_r      <= GN_W'(4096);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lsvr_pkg::CFG_FRAME_COUNT: begin
                    r_frame_count <= i_cfg_data[lsvr_pkg::FC_W-1:0];
                end
                lsvr_pkg::CFG_LOOP_BEGIN: begin
                    r_loop_begin <= i_cfg_data[lsvr_pkg::LB_W-1:0];
                end
                lsvr_pkg::CFG_LOOP_FINISH: begin
                    r_loop_finish <= i_cfg_data[lsvr_pkg::LF_W-1:0];
                end
                lsvr_pkg::CFG_LOOP_ENABLE: begin
                    r_loop_enable <= i_cfg_data[0];
                end
                lsvr_pkg::CFG_STEREO_MODE: begin
                    r_stereo <= i_cfg_data[0];
                end
                lsvr_pkg::CFG_PHASE_STEP: begin
                    r_phase_step <= i_cfg_data[STEP_W-1:0];
                end
                lsvr_pkg::CFG_GAIN_LEFT: begin
                    r_gain_l <= i_cfg_data[GN_W-1:0];
                end
                lsvr_pkg::CFG_GAIN_RIGHT: begin
                    r_gain_r <= i_cfg_data[GN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // loop region
    always_comb begin
        fr32     = 32'(r_frame_count);
        n_frames = (fr32 > 32'(lsvr_pkg::MAX_FRAMES)) ? FR_W'(lsvr_pkg::MAX_FRAMES)
                                                      : FR_W'(r_frame_count);
        fr32     = 32'(n_frames);
        loop_ok  = (r_loop_finish > r_loop_begin) && (r_loop_begin >= 0);
        lb32     = {{(32 - lsvr_pkg::LB_W){1'b0}}, r_loop_begin};
        lf32     = {{(32 - lsvr_pkg::LF_W){1'b0}}, r_loop_finish};
        n_ls     = '0;
        n_le     = n_frames;
        if (loop_ok) begin
            n_ls = (lb32 < fr32 - 32'd1) ? FI_W'(lb32) : FI_W'(fr32 - 32'd1);
            n_le = (lf32 < fr32) ? FR_W'(lf32) : n_frames;
        end
        n_limit  = r_loop_enable ? n_le : n_frames;
    end

    // remainder step and wrap
    always_comb begin
        d_full    = r_cursor - CUR_W'({r_le, {FRAC{1'b0}}});
        trial     = {r_rem, r_q[QI_W-1]};
        trial_sub = trial - {1'b0, r_n};
        n_rem     = (trial >= {1'b0, r_n}) ? FR_W'(trial_sub) : FR_W'(trial);
        wrap_int  = FR_W'(r_ls) + r_rem;
    end

    // frame addresses
    always_comb begin
        f0      = FI_W'(r_cursor >> FRAC);
        f0p1    = FR_W'(f0) + FR_W'(1);
        last    = r_frames - FR_W'(1);
        n_f1    = (f0p1 < last) ? FI_W'(f0p1) : FI_W'(last);
        rd_ch   = i_cmd.rd1 & r_stereo;
        raddr_a = r_stereo ? {r_f0, rd_ch} : {1'b0, r_f0};
        raddr_b = r_stereo ? {r_f1, rd_ch} : {1'b0, r_f1};
        rd_diff = D_W'(rd_b) - D_W'(rd_a);
    end

    always_comb begin
        frac_s   = $signed({1'b0, r_frac});
        gain_l_s = $signed({1'b0, r_gain_l});
        gain_r_s = $signed({1'b0, r_gain_r});
        p_rnd_l  = r_p_l + P_HALF;
        p_rnd_r  = r_p_r + P_HALF;
        sh_l     = p_rnd_l >>> FRAC;
        sh_r     = p_rnd_r >>> FRAC;
        step_x   = (STEPX_W'(r_phase_step) << SH_L) >> SH_R;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else if (i_cmd.cur_clear) begin
            r_cursor <= '0;
        end else if (i_cmd.advance) begin
            r_cursor <= r_cursor + CUR_W'(step_x);
        end else if (i_cmd.wrap_apply) begin
            r_cursor <= CUR_W'({wrap_int, r_dfrac});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_frames <= n_frames;
            r_ls     <= n_ls;
            r_le     <= n_le;
            r_limit  <= n_limit;
        end
        if (i_cmd.check) begin
            r_n     <= r_le - FR_W'(r_ls);
            r_q     <= d_full[CUR_W-1:FRAC];
            r_dfrac <= d_full[FRAC-1:0];
            r_rem   <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_q   <= r_q << 1;
        end
        if (i_cmd.addr) begin
            r_f0   <= f0;
            r_f1   <= n_f1;
            r_frac <= r_cursor[FRAC-1:0];
        end
        if (i_cmd.rd1) begin
            r_a_l <= rd_a;
            r_d_l <= rd_diff;
        end
        if (i_cmd.rd2) begin
            r_a_r <= r_stereo ? rd_a : r_a_l;
            r_d_r <= r_stereo ? rd_diff : r_d_l;
        end
        if (i_cmd.lerp) begin
            r_p_l <= r_d_l * frac_s;
            r_p_r <= r_d_r * frac_s;
        end
        if (i_cmd.sum) begin
            r_v_l <= V_W'(r_a_l) + V_W'(sh_l);
            r_v_r <= V_W'(r_a_r) + V_W'(sh_r);
        end
        if (i_cmd.gain) begin
            r_g_l <= r_v_l * gain_l_s;
            r_g_r <= r_v_r * gain_r_s;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_left   <= i_cmd.zero_out ? '0 : f_round_sat(r_g_l);
            r_right  <= i_cmd.zero_out ? '0 : f_round_sat(r_g_r);
            r_vstate <= i_cmd.vstate;
        end
    end

    always_comb begin
        mem_we = i_cmd.mem_we && (32'(i_sample_address) < 32'(lsvr_pkg::STORE_DEPTH));
        waddr  = AW'(i_sample_address);
    end

    lsvr_store u_store (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (waddr),
        .i_wdata   (i_sample_value),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign o_stat.frames_zero = (r_frames == '0);
    assign o_stat.at_end      = CMP_W'(r_cursor) >= CMP_W'({r_limit, {FRAC{1'b0}}});
    assign o_stat.can_wrap    = r_loop_enable && (r_le > FR_W'(r_ls));
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_left_out    = r_left;
    assign o_right_out   = r_right;
    assign o_voice_state = r_vstate;

endmodule

// ===== hdl/lsvr_ctrl.sv =====
// controller: command decode, voice state and tick sequencing
module lsvr_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [lsvr_pkg::FUNC_W-1:0]     i_func,
    output lsvr_pkg::t_dp_cmd               o_cmd,
    input  lsvr_pkg::t_dp_stat              i_stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_CHECK,
        S_DIV,
        S_WRAP,
        S_ADDR,
        S_RD0,
        S_RD1,
        S_RD2,
        S_LERP,
        S_SUM,
        S_GAIN,
        S_FIN
    } t_state;

    t_state                         r_state;
    logic [lsvr_pkg::FUNC_W-1:0]    r_func;
    lsvr_pkg::t_vstate              r_play;
    logic                           r_stop;
    logic                           r_tick_ok;
    logic [lsvr_pkg::DIV_CW-1:0]    r_cnt;

    lsvr_pkg::t_vstate              n_play;
    logic                           in_accept;
    logic                           out_load;

    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;
    assign in_accept  = i_in_valid && (r_state == S_IDLE) && i_rst_n;
    assign out_load   = (r_state == S_FIN) && i_stat.out_free;

    always_comb begin
        n_play = r_play;
        case (r_func)
            lsvr_pkg::FN_PLAY: begin
                n_play = lsvr_pkg::VS_PLAYING;
            end
            lsvr_pkg::FN_PAUSE: begin
                if (r_play == lsvr_pkg::VS_PLAYING) begin
                    n_play = lsvr_pkg::VS_PAUSED;
                end
            end
            lsvr_pkg::FN_STOP: begin
                n_play = lsvr_pkg::VS_STOPPED;
            end
            lsvr_pkg::FN_TICK: begin
                if (r_stop) begin
                    n_play = lsvr_pkg::VS_STOPPED;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.mem_we     = in_accept && (i_func == lsvr_pkg::FN_WRITE);
        o_cmd.prep       = (r_state == S_PREP);
        o_cmd.check      = (r_state == S_CHECK);
        o_cmd.div_step   = (r_state == S_DIV);
        o_cmd.wrap_apply = (r_state == S_WRAP);
        o_cmd.addr       = (r_state == S_ADDR);
        o_cmd.rd1        = (r_state == S_RD1);
        o_cmd.rd2        = (r_state == S_RD2);
        o_cmd.lerp       = (r_state == S_LERP);
        o_cmd.sum        = (r_state == S_SUM);
        o_cmd.gain       = (r_state == S_GAIN);
        o_cmd.out_load   = out_load;
        o_cmd.zero_out   = !r_tick_ok;
        o_cmd.cur_clear  = out_load && (((r_func == lsvr_pkg::FN_PLAY)
                                         && (r_play != lsvr_pkg::VS_PAUSED))
                                        || (r_func == lsvr_pkg::FN_STOP));
        o_cmd.advance    = out_load && r_tick_ok;
        o_cmd.vstate     = n_play;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_func    <= lsvr_pkg::FN_WRITE;
            r_play    <= lsvr_pkg::VS_INITIAL;
            r_stop    <= 1'b0;
            r_tick_ok <= 1'b0;
            r_cnt     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func    <= i_func;
                        r_stop    <= 1'b0;
                        r_tick_ok <= 1'b0;
                        if ((i_func == lsvr_pkg::FN_TICK)
                            && (r_play == lsvr_pkg::VS_PLAYING)) begin
                            r_state <= S_PREP;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_PREP: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (i_stat.frames_zero) begin
                        r_stop  <= 1'b1;
                        r_state <= S_FIN;
                    end else if (i_stat.at_end) begin
                        if (i_stat.can_wrap) begin
                            r_cnt   <= lsvr_pkg::DIV_CW'(lsvr_pkg::QI_W - 1);
                            r_state <= S_DIV;
                        end else begin
                            r_stop  <= 1'b1;
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_state <= S_ADDR;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_WRAP;
                    end else begin
                        r_cnt <= r_cnt - lsvr_pkg::DIV_CW'(1);
                    end
                end
                S_WRAP: begin
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    r_state <= S_RD0;
                end
                S_RD0: begin
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_state <= S_LERP;
                end
                S_LERP: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    r_tick_ok <= 1'b1;
                    r_state   <= S_FIN;
                end
                S_FIN: begin
                    if (i_stat.out_free) begin
                        r_play  <= n_play;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
